// ===== rtl/store_buffer_with_load_forwarding_assert.svh =====
// Assertion macros for the store buffer
`ifndef STORE_BUFFER_WITH_LOAD_FORWARDING_ASSERT_SVH
`define STORE_BUFFER_WITH_LOAD_FORWARDING_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define SB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// implication whose consequent is checked in the next cycle
`define SB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/sbf_pkg.sv =====
// ----------------------------------------------------------------------------
// sbf_pkg
// Shared types and constants of the store buffer with load forwarding.
// ----------------------------------------------------------------------------
`default_nettype none
package sbf_pkg;
  localparam int Depth      = 16;
  localparam int IdxW       = $clog2(Depth);
  localparam int MaxThreads = 4;
  localparam int BlockShift = 6;
  localparam int DwW        = 37;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_SNOOP  = 2'd1;
  localparam logic [1:0] ACT_DONE   = 2'd2;
  localparam logic [1:0] ACT_TICK   = 2'd3;

  localparam logic [2:0] K_INSERTED = 3'd0;
  localparam logic [2:0] K_REJECT   = 3'd1;
  localparam logic [2:0] K_NOCONF   = 3'd2;
  localparam logic [2:0] K_FORWARD  = 3'd3;
  localparam logic [2:0] K_REPLAY   = 3'd4;
  localparam logic [2:0] K_MEMREQ   = 3'd5;
  localparam logic [2:0] K_RETIRE   = 3'd6;
  localparam logic [2:0] K_DONEACK  = 3'd7;

  localparam logic [1:0] ST_INSERTED = 2'd0;
  localparam logic [1:0] ST_IN_MEM   = 2'd1;
  localparam logic [1:0] ST_DONE     = 2'd2;

  localparam logic [1:0] REG_ACTIVE_CONTEXTS = 2'd0;

  typedef struct packed {
    logic [1:0] thread;
    logic [7:0] mask;
    logic       block;
    logic [1:0] status;
  } ctrl_t;
endpackage
`default_nettype wire

// ===== rtl/store_buffer_with_load_forwarding.sv =====
// ----------------------------------------------------------------------------
// store_buffer_with_load_forwarding
// Age-ordered store buffer shared by threads, with store-to-load forwarding.
// ----------------------------------------------------------------------------
// Input channel in_*: one item per action (insert, snoop, memory done, tick).
// Result channel out_*: zero to four results per item, the final one with
// out_last set. Handshake is valid/ready on both sides; results sit in one
// output register, so a stalled receiver holds the block until it is taken.
// A tick keeps its newest result staged until the next one or the end of
// the tick is known, so the last flag is always right.
// Data, address and control live in synchronous memories (registered read);
// per-entry valid bits are flip-flops cleared by reset, pointers reset to 0.
// A snoop reads one entry at a time, youngest first, until a match or the
// oldest entry; a tick scans from the oldest entry once per active thread
// and skips retired holes at the oldest end one at a time. One item is in
// flight at a time; the next is taken once the last result has gone.
// active_contexts (APB, offset 0) resets to 1; the user must write it only
// while idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none
module store_buffer_with_load_forwarding (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_action,
  input  wire logic [1:0]  in_thread_id,
  input  wire logic [39:0] in_byte_address,
  input  wire logic [7:0]  in_byte_mask,
  input  wire logic        in_block_access,
  input  wire logic [63:0] in_store_data,
  input  wire logic [3:0]  in_entry_index,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       out_kind,
  output logic [3:0]       out_entry,
  output logic [1:0]       out_result_thread,
  output logic [39:0]      out_result_address,
  output logic [7:0]       out_result_mask,
  output logic [63:0]      out_result_data,
  output logic             out_last,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [1:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  import sbf_pkg::*;
  `include "store_buffer_with_load_forwarding_assert.svh"

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_READ  = 7'b0000010,
    S_EVAL  = 7'b0000100,
    S_EMIT  = 7'b0001000,
    S_SCAN  = 7'b0010000,
    S_SDATA = 7'b0100000,
    S_SOUT  = 7'b1000000
  } state_t;

  // memories
  logic [63:0]    mem_data [Depth];
  logic [DwW-1:0] mem_addr [Depth];
  ctrl_t          mem_ctrl [Depth];
  logic [Depth-1:0] valid_r, valid_nxt;

  logic           wr_en, wr_full;
  logic [IdxW-1:0] wr_idx;
  ctrl_t          wr_ctrl;
  logic [63:0]    wr_data;
  logic [DwW-1:0] wr_addr;
  logic [IdxW-1:0] rd_idx;
  logic [63:0]    rd_data;
  logic [DwW-1:0] rd_addr;
  ctrl_t          rd_ctrl;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ctrl[wr_idx] <= wr_ctrl;
      if (wr_full) begin
        mem_data[wr_idx] <= wr_data;
        mem_addr[wr_idx] <= wr_addr;
      end
    end
    rd_data <= mem_data[rd_idx];
    rd_addr <= mem_addr[rd_idx];
    rd_ctrl <= mem_ctrl[rd_idx];
  end

  state_t state_r, state_nxt;
  logic [IdxW-1:0] oldest_r, oldest_nxt, young_r, young_nxt;
  logic [IdxW:0]   occ_r, occ_nxt, k_r, k_nxt;
  logic [2:0]      actx_r;
  logic [1:0]      thr_scan_r, thr_scan_nxt;
  logic            held_r, held_nxt;
  logic            scan_done_r, scan_done_nxt;

  // latched item
  logic [1:0]  act_r, thr_r;
  logic [39:0] baddr_r;
  logic [7:0]  bmask_r;
  logic        blk_r;
  logic [63:0] sdata_r;
  logic [3:0]  eidx_r;
  logic [IdxW-1:0] hit_r, hit_nxt;
  logic [2:0]  hkind_r, hkind_nxt;

  logic        ov_r, ov_nxt, ol_r, ol_nxt;
  logic [2:0]  ok_r, ok_nxt;
  logic [3:0]  oe_r, oe_nxt;
  logic [1:0]  ot_r, ot_nxt;
  logic [39:0] oa_r, oa_nxt;
  logic [7:0]  om_r, om_nxt;
  logic [63:0] od_r, od_nxt;

  // staged tick result
  logic [2:0]  pk_r, pk_nxt;
  logic [3:0]  pe_r, pe_nxt;
  logic [1:0]  pt_r, pt_nxt;
  logic [39:0] pa_r, pa_nxt;
  logic [7:0]  pm_r, pm_nxt;
  logic [63:0] pd_r, pd_nxt;

  logic [2:0] limit;
  logic [DwW-1:0] ldw;
  logic [IdxW-1:0] slot_k;
  logic [IdxW:0] kd;

  // holes at the oldest end are skipped one per cycle, in a tick only while the output is not stalled
  logic drop;
  assign drop = (occ_r != '0) && !valid_r[oldest_r];

  assign limit = (actx_r > 3'(MaxThreads)) ? 3'(MaxThreads) : actx_r;
  assign ldw = baddr_r[39:3];
  assign kd = k_r - 1'b1;
  assign slot_k = oldest_r + kd[IdxW-1:0];

  assign pready = 1'b1;
  assign prdata = (paddr == REG_ACTIVE_CONTEXTS) ? {29'd0, actx_r} : 32'd0;
  assign in_ready = (state_r == S_IDLE) && !ov_r && !drop;

  always_ff @(posedge clk) begin
    if (!rst_n) actx_r <= 3'd1;
    else if (psel && penable && pwrite && paddr == REG_ACTIVE_CONTEXTS)
      actx_r <= pwdata[2:0];
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      act_r <= in_action; thr_r <= in_thread_id; baddr_r <= in_byte_address;
      bmask_r <= in_byte_mask; blk_r <= in_block_access;
      sdata_r <= in_store_data; eidx_r <= in_entry_index;
    end
    hit_r <= hit_nxt; hkind_r <= hkind_nxt;
    ok_r <= ok_nxt; oe_r <= oe_nxt; ot_r <= ot_nxt; oa_r <= oa_nxt;
    om_r <= om_nxt; od_r <= od_nxt; ol_r <= ol_nxt;
    pk_r <= pk_nxt; pe_r <= pe_nxt; pt_r <= pt_nxt; pa_r <= pa_nxt;
    pm_r <= pm_nxt; pd_r <= pd_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; valid_r <= '0; oldest_r <= '0; young_r <= '0;
      occ_r <= '0; k_r <= '0; thr_scan_r <= '0; held_r <= 1'b0;
      scan_done_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; valid_r <= valid_nxt; oldest_r <= oldest_nxt;
      young_r <= young_nxt; occ_r <= occ_nxt; k_r <= k_nxt;
      thr_scan_r <= thr_scan_nxt; held_r <= held_nxt;
      scan_done_r <= scan_done_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; valid_nxt = valid_r; oldest_nxt = oldest_r;
    young_nxt = young_r; occ_nxt = occ_r; k_nxt = k_r;
    thr_scan_nxt = thr_scan_r; held_nxt = held_r; scan_done_nxt = scan_done_r;
    hit_nxt = hit_r; hkind_nxt = hkind_r;
    ov_nxt = ov_r; ok_nxt = ok_r; oe_nxt = oe_r; ot_nxt = ot_r; oa_nxt = oa_r;
    om_nxt = om_r; od_nxt = od_r; ol_nxt = ol_r;
    pk_nxt = pk_r; pe_nxt = pe_r; pt_nxt = pt_r; pa_nxt = pa_r;
    pm_nxt = pm_r; pd_nxt = pd_r;
    wr_en = 1'b0; wr_full = 1'b0; wr_idx = young_r; wr_ctrl = '0;
    wr_data = sdata_r; wr_addr = ldw; rd_idx = slot_k;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (drop) begin
          oldest_nxt = oldest_r + 1'b1;
          occ_nxt = occ_r - 1'b1;
        end else if (in_valid && !ov_r) begin
          state_nxt = S_READ;
        end
      end
      S_READ: begin
        state_nxt = S_EVAL;
        k_nxt = occ_r; hkind_nxt = K_NOCONF; held_nxt = 1'b0;
        thr_scan_nxt = '0;
        unique case (act_r)
          ACT_INSERT: begin
            ok_nxt = K_REJECT; oe_nxt = '0; ot_nxt = thr_r; oa_nxt = '0;
            om_nxt = '0; od_nxt = '0; ol_nxt = 1'b1;
            if (occ_r < (IdxW+1)'(Depth) && {1'b0, thr_r} < 3'(MaxThreads)) begin
              wr_en = 1'b1; wr_full = 1'b1;
              wr_ctrl = '{thread: thr_r, mask: bmask_r, block: blk_r,
                          status: ST_INSERTED};
              valid_nxt[young_r] = 1'b1;
              young_nxt = young_r + 1'b1;
              occ_nxt = occ_r + 1'b1;
              ok_nxt = K_INSERTED; oe_nxt = 4'(young_r); oa_nxt = {ldw, 3'd0};
              om_nxt = bmask_r; od_nxt = sdata_r;
            end
            ov_nxt = 1'b1; state_nxt = S_EMIT;
          end
          ACT_DONE: rd_idx = eidx_r[IdxW-1:0];
          ACT_SNOOP: state_nxt = S_SCAN;
          default: begin
            state_nxt = S_SCAN;
            scan_done_nxt = 1'b0;
            if (limit == '0 || occ_r == '0) state_nxt = S_IDLE;
            k_nxt = '0;
          end
        endcase
      end
      S_EVAL: begin
        // memory done: rd_* holds the entry
        state_nxt = S_IDLE;
        if (valid_r[eidx_r[IdxW-1:0]] && rd_ctrl.status == ST_IN_MEM) begin
          wr_en = 1'b1; wr_idx = eidx_r[IdxW-1:0];
          wr_ctrl = rd_ctrl; wr_ctrl.status = ST_DONE;
          ok_nxt = K_DONEACK; oe_nxt = eidx_r; ot_nxt = rd_ctrl.thread;
          oa_nxt = {rd_addr, 3'd0}; om_nxt = rd_ctrl.mask; od_nxt = rd_data;
          ol_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!ov_r || out_ready) state_nxt = S_IDLE;
      end
      S_SCAN: begin
        // issue read of next slot; snoop walks down, tick walks up
        if (act_r == ACT_SNOOP) begin
          if (k_r == '0) begin
            state_nxt = S_SOUT;
          end else begin
            rd_idx = slot_k; hit_nxt = slot_k; k_nxt = kd;
            state_nxt = S_SDATA;
          end
        end else begin
          rd_idx = oldest_r + k_r[IdxW-1:0]; hit_nxt = rd_idx;
          if (k_r >= occ_r) state_nxt = S_SOUT;
          else begin
            k_nxt = k_r + 1'b1; state_nxt = S_SDATA;
          end
        end
      end
      S_SDATA: begin
        state_nxt = S_SCAN;
        if (act_r == ACT_SNOOP) begin
          if (valid_r[hit_r] && rd_ctrl.thread == thr_r &&
              rd_addr[DwW-1:BlockShift-3] == ldw[DwW-1:BlockShift-3]) begin
            if (blk_r || rd_ctrl.block) begin
              hkind_nxt = (blk_r && rd_ctrl.block) ? K_FORWARD : K_REPLAY;
            end else if (rd_addr == ldw) begin
              if ((bmask_r & rd_ctrl.mask) == bmask_r) hkind_nxt = K_FORWARD;
              else if ((bmask_r & rd_ctrl.mask) != '0) hkind_nxt = K_REPLAY;
            end
            if (hkind_nxt != K_NOCONF) begin
              ok_nxt = hkind_nxt; oe_nxt = 4'(hit_r); ot_nxt = thr_r;
              oa_nxt = {rd_addr, 3'd0}; om_nxt = rd_ctrl.mask;
              od_nxt = (hkind_nxt == K_FORWARD) ? rd_data : 64'd0;
              ol_nxt = 1'b1; ov_nxt = 1'b1; state_nxt = S_EMIT;
            end
          end
        end else if (valid_r[hit_r] && rd_ctrl.thread == thr_scan_r) begin
          // oldest store of this thread
          state_nxt = S_SOUT; scan_done_nxt = 1'b1;
          if (rd_ctrl.status == ST_INSERTED) begin
            wr_en = 1'b1; wr_idx = hit_r; wr_ctrl = rd_ctrl;
            wr_ctrl.status = ST_IN_MEM; pk_nxt = K_MEMREQ;
          end else if (rd_ctrl.status == ST_DONE) begin
            valid_nxt[hit_r] = 1'b0; pk_nxt = K_RETIRE;
          end else scan_done_nxt = 1'b0;
          pe_nxt = 4'(hit_r); pt_nxt = rd_ctrl.thread;
          pa_nxt = {rd_addr, 3'd0}; pm_nxt = rd_ctrl.mask; pd_nxt = rd_data;
        end
      end
      S_SOUT: begin
        if (act_r == ACT_SNOOP) begin
          ok_nxt = K_NOCONF; oe_nxt = '0; ot_nxt = thr_r; oa_nxt = '0;
          om_nxt = '0; od_nxt = '0; ol_nxt = 1'b1; ov_nxt = 1'b1;
          state_nxt = S_EMIT;
        end else if (!ov_r || out_ready) begin
          if (scan_done_r) begin
            if (held_r) begin
              // a newer result exists, so the held one is not the last
              ov_nxt = 1'b1; ol_nxt = 1'b0; held_nxt = 1'b0;
            end else begin
              ok_nxt = pk_r; oe_nxt = pe_r; ot_nxt = pt_r; oa_nxt = pa_r;
              om_nxt = pm_r; od_nxt = pd_r; held_nxt = 1'b1;
              scan_done_nxt = 1'b0;
            end
          end else if (drop) begin
            oldest_nxt = oldest_r + 1'b1; occ_nxt = occ_r - 1'b1;
          end else if ({1'b0, thr_scan_r} + 3'd1 >= limit || occ_r == '0) begin
            // tick ends; the held result is the last one
            if (held_r) begin
              ol_nxt = 1'b1; ov_nxt = 1'b1; held_nxt = 1'b0;
            end
            state_nxt = S_EMIT;
          end else begin
            thr_scan_nxt = thr_scan_r + 1'b1; k_nxt = '0; state_nxt = S_SCAN;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid = ov_r;
  assign out_kind = ok_r;
  assign out_entry = oe_r;
  assign out_result_thread = ot_r;
  assign out_result_address = oa_r;
  assign out_result_mask = om_r;
  assign out_result_data = od_r;
  assign out_last = ol_r;

  `SB_ASSERT_IMP(a_occ_range, 1'b1, occ_r <= (IdxW+1)'(Depth), "occupancy overflow")
  `SB_ASSERT_IMP(a_idle_ready, in_ready, state_r == S_IDLE, "ready outside idle")
  `SB_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped")
  `SB_ASSERT_IMP(a_held_quiet, held_r, !ov_r, "held result while output busy")
endmodule
`default_nettype wire

// ===== verif/store_buffer_with_load_forwarding_tb.sv =====
// ----------------------------------------------------------------------------
// store_buffer_with_load_forwarding_tb
// Self-checking bench for the store buffer: a directed table of inserts,
// snoops, memory dones and ticks, then random traffic over several thread
// context settings. Every result is checked against a predictor of the buffer.
// ----------------------------------------------------------------------------
`default_nettype none
module store_buffer_with_load_forwarding_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sbf_pkg::*;

  typedef struct {
    logic [1:0]  action;
    logic [1:0]  thread;
    logic [39:0] addr;
    logic [7:0]  mask;
    logic        blk;
    logic [63:0] data;
    logic [3:0]  idx;
    bit          typed;
    logic [2:0]  kind;
  } item_t;

  typedef struct {
    logic [2:0]  kind;
    logic [3:0]  entry;
    logic [1:0]  thread;
    logic [39:0] addr;
    logic [7:0]  mask;
    logic [63:0] data;
    logic        last;
  } result_t;

  logic clk = 1'b0, rst_n = 1'b0;
  logic in_valid = 1'b0, in_ready;
  logic [1:0] in_action = '0, in_thread_id = '0;
  logic [39:0] in_byte_address = '0;
  logic [7:0] in_byte_mask = '0;
  logic in_block_access = 1'b0;
  logic [63:0] in_store_data = '0;
  logic [3:0] in_entry_index = '0;
  logic out_valid, out_ready = 1'b0, out_last;
  logic [2:0] out_kind;
  logic [3:0] out_entry;
  logic [1:0] out_result_thread;
  logic [39:0] out_result_address;
  logic [7:0] out_result_mask;
  logic [63:0] out_result_data;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0, pready;
  logic [1:0] paddr = '0;
  logic [31:0] pwdata = '0, prdata;

  store_buffer_with_load_forwarding dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // predictor state
  logic [63:0] sb_data [Depth];
  logic [36:0] sb_dw [Depth];
  logic        sb_valid [Depth];
  logic [1:0]  sb_thr [Depth];
  logic [7:0]  sb_mask [Depth];
  logic        sb_blk [Depth];
  logic [1:0]  sb_status [Depth];
  int head = 0, tail = 0, count = 0;
  int contexts = 1;

  result_t pending_results[$];
  int mismatch_count = 0;
  bit calm = 1'b0;
  logic [39:0] hot_blocks [4];

  function automatic result_t entry_result(logic [2:0] kind, int s);
    result_t r;
    r = '{kind, s[3:0], sb_thr[s], {sb_dw[s], 3'b000}, sb_mask[s], sb_data[s], 1'b0};
    return r;
  endfunction

  // Applies one accepted item to the buffer copy and queues its results.
  function automatic int buffer_effects(item_t it);
    result_t res[$];
    logic [36:0] dw;
    logic [2:0] kind;
    int hit, s, limit;
    bit found;
    dw = it.addr[39:3];
    hit = 0;
    case (it.action)
      ACT_INSERT: begin
        if (count >= Depth) begin
          res.push_back('{K_REJECT, 4'd0, it.thread, 40'd0, 8'd0, 64'd0, 1'b0});
        end else begin
          s = tail;
          sb_data[s] = it.data;
          sb_dw[s] = dw;
          sb_valid[s] = 1'b1;
          sb_thr[s] = it.thread;
          sb_mask[s] = it.mask;
          sb_blk[s] = it.blk;
          sb_status[s] = ST_INSERTED;
          tail = (tail + 1) % Depth;
          count++;
          res.push_back(entry_result(K_INSERTED, s));
        end
      end
      ACT_SNOOP: begin
        kind = K_NOCONF;
        for (int k = count - 1; k >= 0 && kind == K_NOCONF; k--) begin
          s = (head + k) % Depth;
          if (!sb_valid[s] || sb_thr[s] != it.thread) continue;
          if ((sb_dw[s] >> (BlockShift - 3)) != (dw >> (BlockShift - 3))) continue;
          if (it.blk || sb_blk[s]) begin
            kind = (it.blk && sb_blk[s]) ? K_FORWARD : K_REPLAY;
          end else if (sb_dw[s] == dw) begin
            if ((it.mask & sb_mask[s]) == it.mask) kind = K_FORWARD;
            else if ((it.mask & sb_mask[s]) != 0) kind = K_REPLAY;
          end
          hit = s;
        end
        if (kind == K_NOCONF) begin
          res.push_back('{K_NOCONF, 4'd0, it.thread, 40'd0, 8'd0, 64'd0, 1'b0});
        end else begin
          res.push_back('{kind, hit[3:0], it.thread, {sb_dw[hit], 3'b000}, sb_mask[hit],
                          kind == K_FORWARD ? sb_data[hit] : 64'd0, 1'b0});
        end
      end
      ACT_DONE: begin
        if (sb_valid[it.idx] && sb_status[it.idx] == ST_IN_MEM) begin
          sb_status[it.idx] = ST_DONE;
          res.push_back(entry_result(K_DONEACK, int'(it.idx)));
        end
      end
      default: begin
        limit = contexts < MaxThreads ? contexts : MaxThreads;
        for (int t = 0; t < limit && res.size() < 4; t++) begin
          if (count == 0) break;
          found = 1'b0;
          s = 0;
          for (int k = 0; k < count; k++) begin
            s = (head + k) % Depth;
            if (sb_valid[s] && sb_thr[s] == t) begin
              found = 1'b1;
              break;
            end
          end
          if (!found) continue;
          if (sb_status[s] == ST_INSERTED) begin
            sb_status[s] = ST_IN_MEM;
            res.push_back(entry_result(K_MEMREQ, s));
          end else if (sb_status[s] == ST_DONE) begin
            res.push_back(entry_result(K_RETIRE, s));
            sb_valid[s] = 1'b0;
            // oldest pointer skips retired holes
            while (count > 0 && !sb_valid[head]) begin
              head = (head + 1) % Depth;
              count--;
            end
          end
        end
      end
    endcase
    if (res.size() > 0) res[res.size() - 1].last = 1'b1;
    foreach (res[i]) pending_results.push_back(res[i]);
    return res.size();
  endfunction

  task automatic send_item(item_t it);
    int first, n;
    while (!calm && $urandom_range(0, 99) < 21) @(negedge clk);
    in_action = it.action;
    in_thread_id = it.thread;
    in_byte_address = it.addr;
    in_byte_mask = it.mask;
    in_block_access = it.blk;
    in_store_data = it.data;
    in_entry_index = it.idx;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
    first = pending_results.size();
    n = buffer_effects(it);
    if (it.typed && (n == 0 || pending_results[first].kind != it.kind)) begin
      $error("kind: expected %0d, actual %0d", it.kind,
             n == 0 ? 3'd0 : pending_results[first].kind);
      mismatch_count++;
    end
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_contexts(logic [31:0] value);
    wait (pending_results.size() == 0);
    // ticks with no result may still be scanning; ready returns once idle
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    psel = 1'b1;
    pwrite = 1'b1;
    paddr = {REG_ACTIVE_CONTEXTS};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    contexts = value[2:0];
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
  endtask

  function automatic item_t random_item();
    item_t it;
    int r;
    r = $urandom_range(0, 99);
    it.action = r < 35 ? ACT_INSERT : r < 65 ? ACT_SNOOP : r < 80 ? ACT_DONE : ACT_TICK;
    it.thread = 2'($urandom_range(0, 3));
    // mostly a few hot blocks so snoops find stores
    if ($urandom_range(0, 9) == 0) it.addr = 40'({$urandom, $urandom});
    else it.addr = hot_blocks[$urandom_range(0, 3)] + 40'($urandom_range(0, 127));
    r = $urandom_range(0, 9);
    it.mask = r == 0 ? 8'h00 : r == 1 ? 8'hFF : r < 5 ? 8'h0F << (4 * $urandom_range(0, 1))
                                                   : 8'($urandom);
    it.blk = $urandom_range(0, 4) == 0;
    it.data = {$urandom, $urandom};
    it.idx = 4'($urandom);
    it.typed = 1'b0;
    it.kind = K_INSERTED;
    return it;
  endfunction

  item_t table_rows [] = '{
    '{ACT_TICK,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd0,  1'b0, K_INSERTED},
    '{ACT_SNOOP,  2'd0, 40'd0,            8'hFF, 1'b0, 64'd0, 4'd0,  1'b1, K_NOCONF},
    '{ACT_INSERT, 2'd0, 40'hFF_FFFF_FFFF, 8'hFF, 1'b0, '1,    4'd0,  1'b1, K_INSERTED},
    '{ACT_SNOOP,  2'd0, 40'hFF_FFFF_FFF8, 8'h00, 1'b0, 64'd0, 4'd0,  1'b1, K_FORWARD},
    '{ACT_SNOOP,  2'd0, 40'hFF_FFFF_FFF8, 8'h0F, 1'b0, 64'd0, 4'd0,  1'b1, K_FORWARD},
    '{ACT_SNOOP,  2'd1, 40'hFF_FFFF_FFF8, 8'hFF, 1'b0, 64'd0, 4'd0,  1'b1, K_NOCONF},
    '{ACT_INSERT, 2'd0, 40'h100,          8'h0F, 1'b0, 64'h0123_4567_89AB_CDEF, 4'd0,
      1'b1, K_INSERTED},
    '{ACT_SNOOP,  2'd0, 40'h100,          8'hFF, 1'b0, 64'd0, 4'd0,  1'b1, K_REPLAY},
    '{ACT_SNOOP,  2'd0, 40'h104,          8'hF0, 1'b0, 64'd0, 4'd0,  1'b1, K_NOCONF},
    '{ACT_INSERT, 2'd1, 40'h1000,         8'hFF, 1'b1, 64'hA5A5_5A5A_0F0F_F0F0, 4'd0,
      1'b1, K_INSERTED},
    '{ACT_SNOOP,  2'd1, 40'h1008,         8'h01, 1'b1, 64'd0, 4'd0,  1'b1, K_FORWARD},
    '{ACT_SNOOP,  2'd1, 40'h1010,         8'h01, 1'b0, 64'd0, 4'd0,  1'b1, K_REPLAY},
    '{ACT_SNOOP,  2'd1, 40'h1040,         8'h01, 1'b1, 64'd0, 4'd0,  1'b1, K_NOCONF},
    '{ACT_INSERT, 2'd3, 40'h1000,         8'hFF, 1'b0, 64'd7, 4'd0,  1'b1, K_INSERTED},
    '{ACT_DONE,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd0,  1'b0, K_INSERTED},
    '{ACT_TICK,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd0,  1'b1, K_MEMREQ},
    '{ACT_DONE,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd0,  1'b1, K_DONEACK},
    '{ACT_DONE,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd15, 1'b0, K_INSERTED},
    '{ACT_TICK,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd0,  1'b1, K_RETIRE},
    '{ACT_TICK,   2'd0, 40'd0,            8'h00, 1'b0, 64'd0, 4'd0,  1'b1, K_MEMREQ}
  };

  int contexts_plan [] = '{4, 0, 7, 2, 3, 1};

  initial begin
    item_t it;
    foreach (sb_valid[i]) sb_valid[i] = 1'b0;
    foreach (hot_blocks[i]) hot_blocks[i] = 40'({$urandom, $urandom}) & ~40'h7F;
    hot_blocks[3] = 40'hFF_FFFF_FF80;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    foreach (table_rows[i]) send_item(table_rows[i]);
    foreach (contexts_plan[p]) begin
      write_contexts(contexts_plan[p]);
      for (int i = 0; i < 72; i++) begin
        calm = (p == 2 && i >= 10 && i < 60);
        it = random_item();
        send_item(it);
      end
      calm = 1'b0;
    end
    wait (pending_results.size() == 0);
    repeat (100) @(posedge clk);
    if (mismatch_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

  always @(negedge clk) out_ready = calm || $urandom_range(0, 99) >= 21;

  task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", name, want, got);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result with no item pending: kind %0d", out_kind);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", want.kind, out_kind);
        compare_field("entry", want.entry, out_entry);
        compare_field("result_thread", want.thread, out_result_thread);
        compare_field("result_address", want.addr, out_result_address);
        compare_field("result_mask", want.mask, out_result_mask);
        compare_field("result_data", want.data, out_result_data);
        compare_field("last", want.last, out_last);
      end
    end
  end

  initial begin
    #8ms;
    $display("Mismatches found");
    $finish;
  end
endmodule
`default_nettype wire

// ===== store_buffer_with_load_forwarding.f =====
+incdir+rtl
rtl/sbf_pkg.sv
rtl/store_buffer_with_load_forwarding.sv
verif/store_buffer_with_load_forwarding_tb.sv
